@@ hw/rtl/rvcore_pkg.sv @@
// Shared types and constants for the RV32I execute-step core.
package rvcore_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = 5;

  // Major opcodes
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_HALT   = 7'h7F;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;

  // Register that receives the PC on a halt
  localparam logic [REG_IDX_W-1:0] SAVE_REG = 5'd8;

  // Access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Operations of an input transaction
  localparam logic OP_LOAD_WORD = 1'b0;
  localparam logic OP_STEP      = 1'b1;

  // Configuration register indexes
  localparam logic REG_CODE_BASE   = 1'b0;
  localparam logic REG_TRAP_VECTOR = 1'b1;

  // Byte memory access request
  typedef struct packed {
    logic            rd;
    logic            wr;
    logic [XLEN-1:0] addr;
    logic [XLEN-1:0] wdata;
    logic [1:0]      size;
  } mem_req_t;

  // Result of decoding and executing one instruction
  typedef struct packed {
    logic                 bad;
    logic                 wr;
    logic [REG_IDX_W-1:0] rd;
    logic [XLEN-1:0]      wval;
    logic [XLEN-1:0]      next_pc;
    logic                 st;
    logic                 ld;
    logic [XLEN-1:0]      maddr;
    logic [XLEN-1:0]      st_data;
    logic [1:0]           size;
  } exec_res_t;

endpackage

@@ hw/rtl/rvcore_ifs.sv @@
// Valid/ready channel interfaces for input and result transactions.
interface rvcore_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] load_address;
  logic [31:0] load_word;

  modport source (output valid, output operation, output load_address, output load_word,
                  input ready);
  modport sink (input valid, input operation, input load_address, input load_word,
                output ready);
endinterface

interface rvcore_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pc_after;
  logic        halted;
  logic        illegal;
  logic        rd_valid;
  logic [4:0]  rd_index;
  logic [31:0] rd_value;
  logic        store_valid;
  logic [15:0] store_address;
  logic [31:0] store_data;
  logic [1:0]  store_bytes;

  modport source (output valid, output pc_after, output halted, output illegal,
                  output rd_valid, output rd_index, output rd_value, output store_valid,
                  output store_address, output store_data, output store_bytes,
                  input ready);
  modport sink (input valid, input pc_after, input halted, input illegal,
                input rd_valid, input rd_index, input rd_value, input store_valid,
                input store_address, input store_data, input store_bytes,
                output ready);
endinterface

@@ hw/rtl/rvcore_mem.sv @@
// Byte memory: four byte lanes of synchronous RAM, misaligned access, clear after reset.
module rvcore_mem import rvcore_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mem_req_t        req_i,
  output logic [XLEN-1:0] rdata_o,
  output logic            busy_o
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int ROWS = MEM_BYTES / 4;
  localparam int RW   = AW - 2;

  logic [AW-1:0] addr;
  logic [1:0]    off;
  logic [RW-1:0] row;
  logic [1:0]    off_q;
  logic [RW-1:0] clr_row_q, clr_row_d;
  logic          busy_q, busy_d;
  logic [7:0]    lane_rd [4];

  assign addr = req_i.addr[AW-1:0];
  assign off  = addr[1:0];
  assign row  = addr[AW-1:2];

  // Clearing pass, one row per cycle
  always_comb begin
    busy_d    = busy_q;
    clr_row_d = clr_row_q;
    if (busy_q) begin
      clr_row_d = clr_row_q + 1'b1;
      if (clr_row_q == RW'(ROWS - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_row_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_row_q <= clr_row_d;
    end
  end

  assign busy_o = busy_q;

  // Lane l holds byte index (l - off) of the access, one row further up when l < off
  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0]    mem_q [ROWS];
    logic [7:0]    rd_q;
    logic [1:0]    idx;
    logic [RW-1:0] row_l;
    logic          we;
    logic [7:0]    wb;

    assign idx   = 2'(l) - off;
    assign row_l = row + {{(RW-1){1'b0}}, (2'(l) < off)};
    assign we    = req_i.wr && ((req_i.size == SZ_WORD) ||
                                ((req_i.size == SZ_HALF) && !idx[1]) || (idx == 2'd0));
    assign wb    = req_i.wdata[{idx, 3'b000} +: 8];

    always_ff @(posedge clk_i) begin
      if (busy_q) begin
        mem_q[clr_row_q] <= '0;
      end else if (we) begin
        mem_q[row_l] <= wb;
      end
      if (req_i.rd) rd_q <= mem_q[row_l];
    end

    assign lane_rd[l] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) off_q <= off;
  end

  // Reassemble bytes in access order
  always_comb begin
    logic [1:0] sel;
    rdata_o = '0;
    for (int i = 0; i < 4; i++) begin
      sel = 2'(i) + off_q;
      rdata_o[8*i +: 8] = lane_rd[sel];
    end
  end

endmodule

@@ hw/rtl/rvcore_rf.sv @@
// Register file: synchronous RAM with two read ports and valid bits that read as zero.
module rvcore_rf import rvcore_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [REG_IDX_W-1:0] ra_i,
  input  logic [REG_IDX_W-1:0] rb_i,
  output logic [XLEN-1:0]      a_o,
  output logic [XLEN-1:0]      b_o,
  input  logic                 we_i,
  input  logic [REG_IDX_W-1:0] wa_i,
  input  logic [XLEN-1:0]      wd_i
);

  logic [XLEN-1:0]      mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [XLEN-1:0]      a_q, b_q;
  logic                 av_q, bv_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[wa_i] <= wd_i;
    if (rd_en_i) begin
      a_q  <= mem_q[ra_i];
      b_q  <= mem_q[rb_i];
      av_q <= vld_q[ra_i];
      bv_q <= vld_q[rb_i];
    end
  end

  // x0 is never written, so it stays invalid and reads zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[wa_i] <= 1'b1;
    end
  end

  assign a_o = av_q ? a_q : '0;
  assign b_o = bv_q ? b_q : '0;

endmodule

@@ hw/rtl/rvcore_exec.sv @@
// Instruction decode and execute: immediates, ALU, branches, addresses.
module rvcore_exec import rvcore_pkg::*; (
  input  logic [XLEN-1:0] ins_i,
  input  logic [XLEN-1:0] pc_i,
  input  logic [XLEN-1:0] a_i,
  input  logic [XLEN-1:0] b_i,
  input  logic [XLEN-1:0] trap_i,
  output exec_res_t       res_o
);

  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [4:0]      sh_i;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_j, pc4;
  logic            alt, take;

  assign opc   = ins_i[6:0];
  assign f3    = ins_i[14:12];
  assign sh_i  = ins_i[24:20];
  assign alt   = ins_i[30];
  assign imm_i = {{20{ins_i[31]}}, ins_i[31:20]};
  assign imm_s = {{20{ins_i[31]}}, ins_i[31:25], ins_i[11:7]};
  assign imm_b = {{19{ins_i[31]}}, ins_i[31], ins_i[7], ins_i[30:25], ins_i[11:8], 1'b0};
  assign imm_j = {{11{ins_i[31]}}, ins_i[31], ins_i[19:12], ins_i[20], ins_i[30:21], 1'b0};
  assign pc4   = pc_i + 32'd4;

  always_comb begin
    res_o         = '0;
    res_o.rd      = ins_i[11:7];
    res_o.next_pc = pc4;
    take          = 1'b0;
    case (opc)
      OPC_IMM: begin
        res_o.wr = 1'b1;
        case (f3)
          3'd0: res_o.wval = a_i + imm_i;
          3'd1: res_o.wval = a_i << sh_i;
          3'd4: res_o.wval = a_i ^ imm_i;
          3'd5: res_o.wval = alt ? XLEN'($signed(a_i) >>> sh_i) : (a_i >> sh_i);
          3'd6: res_o.wval = a_i | imm_i;
          3'd7: res_o.wval = a_i & imm_i;
          default: begin
            res_o.wr  = 1'b0;
            res_o.bad = 1'b1;
          end
        endcase
      end
      OPC_REG: begin
        res_o.wr = 1'b1;
        case (f3)
          3'd0: res_o.wval = alt ? (a_i - b_i) : (a_i + b_i);
          3'd1: res_o.wval = a_i << b_i[4:0];
          3'd4: res_o.wval = a_i ^ b_i;
          3'd5: res_o.wval = alt ? XLEN'($signed(a_i) >>> b_i[4:0]) : (a_i >> b_i[4:0]);
          3'd6: res_o.wval = a_i | b_i;
          3'd7: res_o.wval = a_i & b_i;
          default: res_o.wr = 1'b0;
        endcase
      end
      OPC_LUI: begin
        res_o.wr   = 1'b1;
        res_o.wval = {ins_i[31:12], 12'b0};
      end
      OPC_JAL: begin
        res_o.wr      = 1'b1;
        res_o.wval    = pc4;
        res_o.next_pc = pc_i + imm_j;
      end
      OPC_JALR: begin
        res_o.wr      = 1'b1;
        res_o.wval    = pc4;
        res_o.next_pc = (a_i + imm_i) & ~32'd1;
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0: take = (a_i == b_i);
          3'd1: take = (a_i != b_i);
          3'd4: take = $signed(a_i) < $signed(b_i);
          3'd5: take = !($signed(a_i) < $signed(b_i));
          default: take = 1'b0;
        endcase
        if (take) res_o.next_pc = pc_i + imm_b;
      end
      OPC_LOAD: begin
        res_o.maddr = a_i + imm_i;
        res_o.size  = f3[1:0];
        res_o.ld    = !f3[2] && (f3[1:0] != 2'd3);
        res_o.wr    = res_o.ld;
      end
      OPC_STORE: begin
        res_o.maddr = a_i + imm_s;
        res_o.size  = f3[1:0];
        res_o.st    = !f3[2] && (f3[1:0] != 2'd3);
        case (f3[1:0])
          SZ_BYTE: res_o.st_data = {24'b0, b_i[7:0]};
          SZ_HALF: res_o.st_data = {16'b0, b_i[15:0]};
          default: res_o.st_data = b_i;
        endcase
      end
      OPC_HALT: begin
        res_o.wr      = 1'b1;
        res_o.rd      = SAVE_REG;
        res_o.wval    = pc_i;
        res_o.next_pc = trap_i;
      end
      default: res_o.bad = 1'b1;
    endcase
  end

endmodule

@@ hw/rtl/rv32i_core_execute_step_core.sv @@
// Top level of the RV32I execute-step core: sequencer, PC, configuration and result register.
//
//   channel | dir | handshake          | carries
//   in_i    | in  | valid/ready        | operation, load_address, load_word
//   out_o   | out | valid/ready        | pc_after, status, register write, store
//   APB     | in  | psel/penable/pready| code_base (0x0), trap_vector (0x4)
//
// A program word load, and a step on a stopped core, are answered from the idle state; a
// step passes through fetch read, register file read and execute, and a memory load
// adds a load state, set by the synchronous byte memory and register file reads.
// After reset the byte memory clears its MEM_BYTES/4 rows with in_i.ready low.
// A finished result waits in the output register; a new transaction is taken once
// it is free or leaving.
module rv32i_core_execute_step_core import rvcore_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rvcore_in_if.sink   in_i,
  rvcore_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [XLEN-1:0] ADDR_MASK = XLEN'(MEM_BYTES - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_LOAD  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [XLEN-1:0] pc_q, pc_d;
  logic            stopped_q, stopped_d;
  logic [15:0]     code_base_q, trap_q;
  logic [XLEN-1:0] ins_q, trap32, mem_rdata, rf_a, rf_b, ld_val;
  logic            mem_busy, in_ready, accept;
  mem_req_t        mem_req;
  exec_res_t       ex;
  logic            rf_rd_en, rf_we;
  logic [XLEN-1:0] rf_wd;
  logic [REG_IDX_W-1:0] rf_wa;

  // Output register
  logic            out_valid_q, out_valid_d, out_load;
  logic [31:0]     pc_after_d, rd_value_d, store_data_d;
  logic            halted_d, illegal_d, rd_valid_d, store_valid_d;
  logic [4:0]      rd_index_d;
  logic [15:0]     store_address_d;
  logic [1:0]      store_bytes_d;
  logic [31:0]     pc_after_q, rd_value_q, store_data_q;
  logic            halted_q, illegal_q, rd_valid_q, store_valid_q;
  logic [4:0]      rd_index_q;
  logic [15:0]     store_address_q;
  logic [1:0]      store_bytes_q;

  assign trap32 = {16'b0, trap_q};

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRAP_VECTOR) ? {16'b0, trap_q} : {16'b0, code_base_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_base_q <= 16'd4096;
      trap_q      <= 16'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_CODE_BASE) code_base_q <= pwdata[15:0];
      else                           trap_q      <= pwdata[15:0];
    end
  end

  rvcore_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  rvcore_rf u_rf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (rf_rd_en),
    .ra_i    (mem_rdata[19:15]),
    .rb_i    (mem_rdata[24:20]),
    .a_o     (rf_a),
    .b_o     (rf_b),
    .we_i    (rf_we),
    .wa_i    (rf_wa),
    .wd_i    (rf_wd)
  );

  rvcore_exec u_exec (
    .ins_i  (ins_q),
    .pc_i   (pc_q),
    .a_i    (rf_a),
    .b_i    (rf_b),
    .trap_i (trap32),
    .res_o  (ex)
  );

  assign in_ready    = (state_q == S_IDLE) && !mem_busy && (!out_valid_q || out_o.ready);
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;

  // Sign extension of loaded data
  always_comb begin
    case (ins_q[13:12])
      SZ_BYTE: ld_val = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
      SZ_HALF: ld_val = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
      default: ld_val = mem_rdata;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d         = state_q;
    pc_d            = pc_q;
    stopped_d       = stopped_q;
    mem_req         = '0;
    rf_rd_en        = 1'b0;
    rf_we           = 1'b0;
    rf_wa           = ex.rd;
    rf_wd           = ex.wval;
    out_valid_d     = out_valid_q && !out_o.ready;
    out_load        = 1'b0;
    pc_after_d      = pc_q;
    halted_d        = stopped_q;
    illegal_d       = 1'b0;
    rd_valid_d      = 1'b0;
    rd_index_d      = '0;
    rd_value_d      = '0;
    store_valid_d   = 1'b0;
    store_address_d = '0;
    store_data_d    = '0;
    store_bytes_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.operation == OP_LOAD_WORD) begin
            mem_req.wr    = 1'b1;
            mem_req.addr  = {16'b0, in_i.load_address};
            mem_req.wdata = in_i.load_word;
            mem_req.size  = SZ_WORD;
            if (pc_q == '0) pc_d = {16'b0, code_base_q};
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            pc_after_d  = pc_d;
          end else if (stopped_q || (pc_q == trap32)) begin
            stopped_d   = 1'b1;
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            halted_d    = 1'b1;
          end else begin
            mem_req.rd   = 1'b1;
            mem_req.addr = pc_q;
            state_d      = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        rf_rd_en = 1'b1;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        if (ex.bad) begin
          stopped_d   = 1'b1;
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          halted_d    = 1'b1;
          illegal_d   = 1'b1;
          state_d     = S_IDLE;
        end else if (ex.ld) begin
          mem_req.rd   = 1'b1;
          mem_req.addr = ex.maddr;
          state_d      = S_LOAD;
        end else begin
          rf_we = ex.wr && (ex.rd != '0);
          if (ex.st) begin
            mem_req.wr    = 1'b1;
            mem_req.addr  = ex.maddr;
            mem_req.wdata = ex.st_data;
            mem_req.size  = ex.size;
          end
          pc_d            = ex.next_pc;
          stopped_d       = (ex.next_pc == trap32);
          out_load        = 1'b1;
          out_valid_d     = 1'b1;
          pc_after_d      = ex.next_pc;
          halted_d        = stopped_d;
          rd_valid_d      = rf_we;
          rd_index_d      = rf_we ? ex.rd : '0;
          rd_value_d      = rf_we ? ex.wval : '0;
          store_valid_d   = ex.st;
          store_address_d = ex.st ? 16'(ex.maddr & ADDR_MASK) : '0;
          store_data_d    = ex.st ? ex.st_data : '0;
          store_bytes_d   = ex.st ? ex.size : '0;
          state_d         = S_IDLE;
        end
      end
      S_LOAD: begin
        rf_wa       = ins_q[11:7];
        rf_wd       = ld_val;
        rf_we       = (rf_wa != '0);
        pc_d        = pc_q + 32'd4;
        stopped_d   = (pc_d == trap32);
        out_load    = 1'b1;
        out_valid_d = 1'b1;
        pc_after_d  = pc_d;
        halted_d    = stopped_d;
        rd_valid_d  = rf_we;
        rd_index_d  = rf_we ? rf_wa : '0;
        rd_value_d  = rf_we ? ld_val : '0;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Instruction and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_FETCH) ins_q <= mem_rdata;
    if (out_load) begin
      pc_after_q      <= pc_after_d;
      halted_q        <= halted_d;
      illegal_q       <= illegal_d;
      rd_valid_q      <= rd_valid_d;
      rd_index_q      <= rd_index_d;
      rd_value_q      <= rd_value_d;
      store_valid_q   <= store_valid_d;
      store_address_q <= store_address_d;
      store_data_q    <= store_data_d;
      store_bytes_q   <= store_bytes_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pc_after      = pc_after_q;
  assign out_o.halted        = halted_q;
  assign out_o.illegal       = illegal_q;
  assign out_o.rd_valid      = rd_valid_q;
  assign out_o.rd_index      = rd_index_q;
  assign out_o.rd_value      = rd_value_q;
  assign out_o.store_valid   = store_valid_q;
  assign out_o.store_address = store_address_q;
  assign out_o.store_data    = store_data_q;
  assign out_o.store_bytes   = store_bytes_q;

endmodule
